// ===== hdl/bicubic_weight_generator_defines.svh =====
// ----------------------------------------------------------------------------
// bicubic weight generator assertion macros
// shared concurrent assertion forms for the weight generator
// ----------------------------------------------------------------------------
`ifndef BICUBIC_WEIGHT_GENERATOR_DEFINES_SVH
`define BICUBIC_WEIGHT_GENERATOR_DEFINES_SVH

// same-cycle implication
`define BWG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BWG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bwg_pkg.sv =====
// ----------------------------------------------------------------------------
// bwg_pkg
// widths, constants, types and rounding for the bicubic weight generator
// ----------------------------------------------------------------------------
package bwg_pkg;

   localparam int POS_W     = 12;
   localparam int RATIO_W   = 24;
   localparam int PHASE_W   = 16;
   localparam int SQUARE_W  = 2 * PHASE_W;
   localparam int CUBE_W    = 3 * PHASE_W;
   localparam int WEIGHT_W  = 16;
   localparam int SUM_W     = 53;
   localparam int FRAC_DROP = 35;
   localparam int Q_W       = SUM_W - FRAC_DROP;

   localparam int BWG_MAX_POSITIONS = 4096;

   localparam logic [RATIO_W-1:0] RATIO_RESET = 24'd65536;

   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic signed [WEIGHT_W-1:0] weight_type;

   // half of a q2.14 lsb in units of 2^-49
   localparam sum_type ROUND_HALF = 53'sh0_0004_0000_0000;
   // the constant two, units of 2^-48
   localparam sum_type TWO_UNITS  = 53'sh2_0000_0000_0000;

   localparam logic signed [Q_W-1:0] Q_MAX = 18'sd32767;
   localparam logic signed [Q_W-1:0] Q_MIN = -18'sd32768;

   typedef struct packed {
      sum_type far_left;
      sum_type near_left;
      sum_type near_right;
      sum_type far_right;
   } tap_sums_type;

   // round half up to q2.14, then saturate
   function automatic weight_type round_sat(sum_type v);
      sum_type                 biased;
      logic signed [Q_W-1:0]   q;
      weight_type              w;
      biased = v + ROUND_HALF;
      q = $signed(biased[SUM_W-1:FRAC_DROP]);
      if (q > Q_MAX) begin
         w = 16'sh7fff;
      end else if (q < Q_MIN) begin
         w = 16'sh8000;
      end else begin
         w = q[WEIGHT_W-1:0];
      end
      return w;
   endfunction

endpackage

// ===== hdl/bwg_tap_sum.sv =====
// ----------------------------------------------------------------------------
// bwg_tap_sum
// forms the four cubic-convolution polynomials from d, d^2 and d^3
// ----------------------------------------------------------------------------
module bwg_tap_sum import bwg_pkg::*; (
   input  logic [PHASE_W-1:0]  phase,
   input  logic [SQUARE_W-1:0] square,
   input  logic [CUBE_W-1:0]   cube,
   output tap_sums_type        sums
);

   sum_type d1;
   sum_type d2;
   sum_type d3;

   // align all powers to units of 2^-48
   assign d1 = $signed({5'b0, phase, 32'b0});
   assign d2 = $signed({5'b0, square, 16'b0});
   assign d3 = $signed({5'b0, cube});

   always_comb begin
      sums.far_left   = (d2 <<< 1) - d3 - d1;
      sums.near_left  = (d3 <<< 1) + d3 - (d2 <<< 2) - d2 + TWO_UNITS;
      sums.near_right = (d2 <<< 2) + d1 - (d3 <<< 1) - d3;
      sums.far_right  = d3 - d2;
   end

endmodule

// ===== hdl/bicubic_weight_generator.sv =====
// ----------------------------------------------------------------------------
// bicubic_weight_generator
// keys cubic-convolution (a = -0.5) tap weights for a polyphase scaler
// ----------------------------------------------------------------------------
// pipeline: an accepted req beat passes one register per stage on its way to rsp_valid
// throughput: one beat per cycle; each stage holds while the stage after it is full
// and stalled, so empty stages still fill while a finished rsp beat waits
// reset: synchronous, clears all stage valid bits and loads inverse_ratio with 1.0
// csr writes are taken in any cycle (csr_ready is always high)
// ----------------------------------------------------------------------------
`include "bicubic_weight_generator_defines.svh"

module bicubic_weight_generator import bwg_pkg::*; #(
   parameter int MAX_POSITIONS = BWG_MAX_POSITIONS
) (
   input  logic                clock,
   input  logic                reset,
   // config write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [RATIO_W-1:0]  csr_inverse_ratio,
   // request
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [POS_W-1:0]    req_position,
   // response
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output weight_type          rsp_weight_far_left,
   output weight_type          rsp_weight_near_left,
   output weight_type          rsp_weight_near_right,
   output weight_type          rsp_weight_far_right
);

   // clamp bounds, compared wide enough to hold the full parameter range
   localparam int                    CMP_W    = 17;
   localparam logic [CMP_W-1:0]      MAX_POS  = CMP_W'(MAX_POSITIONS);
   localparam logic [POS_W-1:0]      POS_LAST = POS_W'(MAX_POSITIONS - 1);

   // ratio register
   logic [RATIO_W-1:0] ratio_ff;

   // stage valid bits and enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic en1, en2, en3, en4, en5;

   // stage payload
   logic [PHASE_W-1:0]  phase1_ff, phase1_in;
   logic [PHASE_W-1:0]  phase2_ff;
   logic [SQUARE_W-1:0] square2_ff, square2_in;
   logic [PHASE_W-1:0]  phase3_ff;
   logic [SQUARE_W-1:0] square3_ff;
   logic [CUBE_W-1:0]   cube3_ff, cube3_in;
   tap_sums_type        sums4_ff, sums4_in;
   weight_type          wfl5_ff, wfl5_in;
   weight_type          wnl5_ff, wnl5_in;
   weight_type          wnr5_ff, wnr5_in;
   weight_type          wfr5_ff, wfr5_in;

   logic [POS_W-1:0]            pos_clamped;
   logic [POS_W+PHASE_W-1:0]    phase_prod;
   logic signed [WEIGHT_W+1:0]  tap_total;

   // ------------------------------------------------------------------
   // config register
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_RESET;
      end else if (csr_valid && csr_ready) begin
         ratio_ff <= csr_inverse_ratio;
      end
   end

   // ------------------------------------------------------------------
   // flow control: a stage loads when it is empty or its successor moves
   // ------------------------------------------------------------------
   assign en5 = !v5_ff || rsp_ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_ready = en1;

   assign v1_in = en1 ? req_valid : v1_ff;
   assign v2_in = en2 ? v1_ff     : v2_ff;
   assign v3_in = en3 ? v2_ff     : v3_ff;
   assign v4_in = en4 ? v3_ff     : v4_ff;
   assign v5_in = en5 ? v4_ff     : v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: clamp position, phase = low 16 bits of position * ratio
   // only the low 16 ratio bits reach the fractional part
   // ------------------------------------------------------------------
   assign pos_clamped = ({{(CMP_W-POS_W){1'b0}}, req_position} >= MAX_POS) ?
                        POS_LAST : req_position;
   assign phase_prod  = pos_clamped * ratio_ff[PHASE_W-1:0];
   assign phase1_in   = phase_prod[PHASE_W-1:0];

   always_ff @(posedge clock) begin
      if (en1) begin
         phase1_ff <= phase1_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: d^2
   // ------------------------------------------------------------------
   assign square2_in = phase1_ff * phase1_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         phase2_ff  <= phase1_ff;
         square2_ff <= square2_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: d^3 (32 x 16 multiply)
   // ------------------------------------------------------------------
   assign cube3_in = square2_ff * phase2_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         phase3_ff  <= phase2_ff;
         square3_ff <= square2_ff;
         cube3_ff   <= cube3_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: exact polynomial sums, units of 2^-49 after the halving
   // ------------------------------------------------------------------
   bwg_tap_sum u_tap_sum (
      .phase  (phase3_ff),
      .square (square3_ff),
      .cube   (cube3_ff),
      .sums   (sums4_in)
   );

   always_ff @(posedge clock) begin
      if (en4) begin
         sums4_ff <= sums4_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: round half up to q2.14 and saturate, output register
   // ------------------------------------------------------------------
   assign wfl5_in = round_sat(sums4_ff.far_left);
   assign wnl5_in = round_sat(sums4_ff.near_left);
   assign wnr5_in = round_sat(sums4_ff.near_right);
   assign wfr5_in = round_sat(sums4_ff.far_right);

   always_ff @(posedge clock) begin
      if (en5) begin
         wfl5_ff <= wfl5_in;
         wnl5_ff <= wnl5_in;
         wnr5_ff <= wnr5_in;
         wfr5_ff <= wfr5_in;
      end
   end

   assign rsp_valid             = v5_ff;
   assign rsp_weight_far_left   = wfl5_ff;
   assign rsp_weight_near_left  = wnl5_ff;
   assign rsp_weight_near_right = wnr5_ff;
   assign rsp_weight_far_right  = wfr5_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   // weights sum to one, each rounding adds at most half an lsb of error
   assign tap_total = {{2{wfl5_ff[WEIGHT_W-1]}}, wfl5_ff}
                    + {{2{wnl5_ff[WEIGHT_W-1]}}, wnl5_ff}
                    + {{2{wnr5_ff[WEIGHT_W-1]}}, wnr5_ff}
                    + {{2{wfr5_ff[WEIGHT_W-1]}}, wfr5_ff};

   `BWG_ASSERT_NOW(a_unity_sum, clock, reset, rsp_valid, (tap_total >= 18'sd16382) && (tap_total <= 18'sd16386), "tap weights do not sum to one")

   `BWG_ASSERT_NOW(a_outer_sign, clock, reset, rsp_valid, (rsp_weight_far_left <= 16'sd0) && (rsp_weight_far_right <= 16'sd0), "outer tap weight is positive")

   `BWG_ASSERT_NEXT(a_accept_fills, clock, reset, req_valid && req_ready, v1_ff, "accepted beat did not enter stage one")

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the bicubic weight generator against its own cubic-convolution
// predictor: directed phases and ratio corners first, then random ratios
// and position runs under three sender/receiver idling mixes
// ----------------------------------------------------------------------------
module tb;
   import bwg_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int MAX_REPORTS  = 10;

   // one expected weight set plus the inputs that produced it
   typedef struct {
      logic [POS_W-1:0]   position;
      logic [RATIO_W-1:0] ratio;
      weight_type         far_left;
      weight_type         near_left;
      weight_type         near_right;
      weight_type         far_right;
   } tap_weights_type;

   // all inputs known from time zero
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [RATIO_W-1:0] csr_inverse_ratio = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [POS_W-1:0]   req_position = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   weight_type         rsp_weight_far_left;
   weight_type         rsp_weight_near_left;
   weight_type         rsp_weight_near_right;
   weight_type         rsp_weight_far_right;

   // predictor copy of the ratio register
   logic [RATIO_W-1:0] ratio_model = RATIO_RESET;
   // weight sets still owed by the block, oldest first
   tap_weights_type    expected_weights[$];

   int tx_idle_pct    = 12;
   int rx_idle_pct    = 81;
   int mismatch_count = 0;
   int cycle_count    = 0;

   bicubic_weight_generator dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_inverse_ratio     (csr_inverse_ratio),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_position          (req_position),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_weight_far_left   (rsp_weight_far_left),
      .rsp_weight_near_left  (rsp_weight_near_left),
      .rsp_weight_near_right (rsp_weight_near_right),
      .rsp_weight_far_right  (rsp_weight_far_right)
   );

   always #5 clock = ~clock;

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // value in units of 2^-49 -> q2.14, round half up, then saturate
   function automatic weight_type round_to_q2_14(input longint v);
      longint biased;
      longint q;
      biased = v + (longint'(1) << 52) + (longint'(1) << 34);
      if (biased < 0) begin
         biased = 0;
      end
      q = (biased >>> 35) - (longint'(1) << 17);
      if (q > 32767) begin
         q = 32767;
      end else if (q < -32768) begin
         q = -32768;
      end
      return weight_type'(q[WEIGHT_W-1:0]);
   endfunction

   // keys a = -0.5 weights for the phase of position * ratio
   function automatic tap_weights_type keys_weights(input logic [POS_W-1:0] pos,
                                                    input logic [RATIO_W-1:0] ratio);
      tap_weights_type       w;
      longint unsigned       clamped;
      longint unsigned       src_pos;
      longint                d1;
      longint                d2;
      longint                d3;
      longint                one;
      clamped = pos;
      // positions past the table stick at the last entry
      if (clamped >= BWG_MAX_POSITIONS) begin
         clamped = BWG_MAX_POSITIONS - 1;
      end
      src_pos = clamped * longint'(ratio);
      // fractional part only, q0.16
      d1 = longint'(src_pos & 64'hffff);
      // scale every power of d to units of 2^-48
      d3 = d1 * d1 * d1;
      d2 = (d1 * d1) << 16;
      d1 = d1 << 32;
      one = longint'(1) << 48;
      w.position   = pos;
      w.ratio      = ratio;
      w.far_left   = round_to_q2_14(-d3 + 2 * d2 - d1);
      w.near_left  = round_to_q2_14(3 * d3 - 5 * d2 + 2 * one);
      w.near_right = round_to_q2_14(-3 * d3 + 4 * d2 + d1);
      w.far_right  = round_to_q2_14(d3 - d2);
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // each rsp beat is held against the oldest open expectation
   always @(posedge clock) begin : rsp_check
      tap_weights_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_weights.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("unexpected rsp beat: %0d %0d %0d %0d",
                        rsp_weight_far_left, rsp_weight_near_left,
                        rsp_weight_near_right, rsp_weight_far_right);
            end
         end else begin
            exp_w = expected_weights.pop_front();
            if (rsp_weight_far_left   !== exp_w.far_left   ||
                rsp_weight_near_left  !== exp_w.near_left  ||
                rsp_weight_near_right !== exp_w.near_right ||
                rsp_weight_far_right  !== exp_w.far_right) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("mismatch pos=%0d ratio=%0d exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                           exp_w.position, exp_w.ratio,
                           exp_w.far_left, exp_w.near_left,
                           exp_w.near_right, exp_w.far_right,
                           rsp_weight_far_left, rsp_weight_near_left,
                           rsp_weight_near_right, rsp_weight_far_right);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // one req beat; valid stays up between back-to-back beats
   task automatic send_position(input logic [POS_W-1:0] pos);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
      expected_weights.push_back(keys_weights(pos, ratio_model));
   endtask

   // drop valid and wait for every owed weight set
   task automatic finish_requests();
      req_valid <= 1'b0;
      while (expected_weights.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // csr beat, only ever issued with the pipe empty
   task automatic write_ratio(input logic [RATIO_W-1:0] value);
      finish_requests();
      csr_valid         <= 1'b1;
      csr_inverse_ratio <= value;
      do @(posedge clock); while (!csr_ready);
      ratio_model = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset ratio is 1.0, so every phase is zero
   task automatic test_reset_ratio();
      send_position(12'd0);
      send_position(12'd1);
      send_position(12'd2048);
      send_position(12'd4095);
   endtask

   // zero ratio pins the phase at zero for any position
   task automatic test_zero_ratio();
      write_ratio(24'd0);
      send_position(12'd0);
      send_position(12'd1234);
      send_position(12'd4095);
   endtask

   // ratio 0.5: odd positions land exactly on half a pixel
   task automatic test_half_phase();
      write_ratio(24'd32768);
      send_position(12'd1);
      send_position(12'd2);
      send_position(12'd4095);
   endtask

   // smallest and largest ratio, smallest and largest phases
   task automatic test_ratio_extremes();
      write_ratio(24'd1);
      send_position(12'd0);
      send_position(12'd1);
      send_position(12'd4095);
      write_ratio(24'hffffff);
      // position 1 gives phase 0xffff, the largest one
      send_position(12'd1);
      send_position(12'd2);
      send_position(12'd4095);
      send_position(12'd0);
   endtask

   // random ratios, mostly in-order scan runs like a real scaler walk
   task automatic test_random_sweep(input int tx_pct, input int rx_pct);
      int               seg;
      int               count;
      int               sent;
      int               run;
      int               j;
      logic [POS_W-1:0] pos;
      logic [RATIO_W-1:0] ratio;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (seg = 0; seg < 4; seg++) begin
         case ($urandom_range(5))
            0: ratio = RATIO_W'($urandom_range(255, 1));
            1: ratio = RATIO_W'($urandom);
            2: ratio = RATIO_W'($urandom_range(131072, 32768));
            3: ratio = 24'hffffff;
            4: ratio = RATIO_W'(1) << $urandom_range(23);
            default: ratio = RATIO_W'(65536 + $urandom_range(64) - 32);
         endcase
         write_ratio(ratio);
         count = $urandom_range(48, 36);
         sent  = 0;
         while (sent < count) begin
            if ($urandom_range(2) != 0) begin
               // consecutive output positions, wrapping at the top
               pos = POS_W'($urandom);
               run = $urandom_range(12, 4);
               for (j = 0; j < run; j++) begin
                  send_position(pos);
                  pos = pos + 1'b1;
                  sent++;
               end
            end else begin
               case ($urandom_range(5))
                  0: pos = '0;
                  1: pos = '1;
                  default: pos = POS_W'($urandom);
               endcase
               send_position(pos);
               sent++;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_ratio();
      test_zero_ratio();
      test_half_phase();
      test_ratio_extremes();
      // sender mostly busy, receiver mostly stalled
      test_random_sweep(12, 81);
      // sender mostly idle, receiver mostly ready
      test_random_sweep(81, 12);
      // full rate on both sides
      test_random_sweep(0, 0);
      finish_requests();
      // let any stray late beat show up before judging
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_weights.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
